FILE: sv/bil_pkg.sv
// Shared types and codes for the bounded insertable list unit.
package bil_pkg;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_INSERT_AT  = 3'd2;
  localparam logic [2:0] MODE_GET_AT     = 3'd3;
  localparam logic [2:0] MODE_POP_BACK   = 3'd4;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd5;
  localparam logic [2:0] MODE_CLEAR      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OOB  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  item_index;
    logic [31:0] item_data;
  } bil_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  count_now;
  } bil_out_t;

  // What one cell does with its word at the next edge
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_FROM_LEFT,
    ACT_FROM_RIGHT,
    ACT_ZERO
  } cell_act_t;

endpackage

FILE: sv/bil_cell.sv
// One storage cell of the list: holds a word, loads, shifts from a neighbour or zeroes.
module bil_cell #(
  parameter int DATA_W = 32
) (
  input  logic                 clk,
  input  bil_pkg::cell_act_t   act,
  input  logic [DATA_W-1:0]    new_word,
  input  logic [DATA_W-1:0]    left_word,
  input  logic [DATA_W-1:0]    right_word,
  output logic [DATA_W-1:0]    word
);
  import bil_pkg::*;

  always_ff @(posedge clk) begin
    unique case (act)
      ACT_LOAD:       word <= new_word;
      ACT_FROM_LEFT:  word <= left_word;
      ACT_FROM_RIGHT: word <= right_word;
      ACT_ZERO:       word <= '0;
      default:        word <= word;
    endcase
  end

endmodule

FILE: sv/bounded_insertable_list_unit.sv
// Top level of the bounded insertable list: control, row of cells and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid / in_ready    | in_item  (mode, index, data)
//  out     | output    | out_valid / out_ready  | out_item (status, data, count)
//
// One word per cycle: the operation, a whole-list shift included, completes in
// the accepting cycle and its result sits in the output register the next.
// A new word is taken whenever the output register is empty or being drained,
// so a stall on the output side holds the input only while a result waits.
// Reset (rst, synchronous) empties the count and the output register; cells
// keep their contents, which are never read before being written.
module bounded_insertable_list_unit #(
  parameter int CAPACITY = 16,
  parameter int DATA_W   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bil_pkg::bil_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output bil_pkg::bil_out_t out_item
);
  import bil_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);     // count width
  localparam int IW    = $clog2(CAPACITY);         // cell index width
  localparam int CMP_W = (CW > 5) ? CW : 5;        // width for index against count

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DATA_W-1:0] words [CAPACITY];
  cell_act_t         acts  [CAPACITY];
  logic [DATA_W-1:0] new_word;
  logic              fire;

  // decoded operation
  logic              do_ins;
  logic              do_pop_back;
  logic              do_pop_front;
  logic              do_clear;
  logic              do_get;
  logic [CW-1:0]     ins_pos;
  logic [1:0]        status;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              full;
  logic [CW-1:0]     last;
  logic [DATA_W-1:0] rd_word;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign new_word = DATA_W'(in_item.item_data);
  assign idx_c    = CMP_W'(in_item.item_index);
  assign cnt_c    = CMP_W'(count);
  assign full     = (count >= CW'(CAPACITY));
  assign last     = count - CW'(1);

  // Decode the operation against the current count.
  always_comb begin
    do_ins       = 1'b0;
    do_pop_back  = 1'b0;
    do_pop_front = 1'b0;
    do_clear     = 1'b0;
    do_get       = 1'b0;
    ins_pos      = '0;
    status       = ST_OK;
    unique case (in_item.mode)
      MODE_PUSH_BACK: begin
        if (full) status = ST_FULL;
        else begin
          do_ins  = 1'b1;
          ins_pos = count;
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_INSERT_AT: begin
        // out-of-range index is reported ahead of a full list
        if (idx_c > cnt_c) status = ST_OOB;
        else if (full) status = ST_FULL;
        else begin
          do_ins  = 1'b1;
          ins_pos = CW'(idx_c);
        end
      end
      MODE_GET_AT: begin
        if (idx_c >= cnt_c) status = ST_OOB;
        else do_get = 1'b1;
      end
      MODE_POP_BACK:  do_pop_back  = (count != '0);
      MODE_POP_FRONT: do_pop_front = (count != '0);
      MODE_CLEAR:     do_clear     = 1'b1;
      default: ;
    endcase
  end

  // Per-cell action: each cell compares its own place with the insert point
  // and with the count or the last occupied place.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      acts[k] = ACT_HOLD;
      if (fire) begin
        if (do_clear) acts[k] = ACT_ZERO;
        else if (do_ins) begin
          if (CW'(k) == ins_pos) acts[k] = ACT_LOAD;
          else if (CW'(k) > ins_pos && CW'(k) <= count) acts[k] = ACT_FROM_LEFT;
        end else if (do_pop_back) begin
          if (CW'(k) == last) acts[k] = ACT_ZERO;
        end else if (do_pop_front) begin
          if (CW'(k) < last) acts[k] = ACT_FROM_RIGHT;
          else if (CW'(k) == last) acts[k] = ACT_ZERO;
        end
      end
    end
  end

  always_comb begin
    priority if (do_clear) count_next = '0;
    else if (do_ins) count_next = count + CW'(1);
    else if (do_pop_back || do_pop_front) count_next = last;
    else count_next = count;
  end

  // Row of cells; the ends see zero beyond the list.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[k+1];
    end
    bil_cell #(.DATA_W(DATA_W)) u_cell (
      .clk        (clk),
      .act        (acts[k]),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[k])
    );
  end

  // Read select; drive zero unless a get is in range.
  assign rd_word = do_get ? words[IW'(in_item.item_index)] : '0;

  // Hold the count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.status    <= status;
      out_item.read_data <= 32'(rd_word);
      out_item.count_now <= 5'(count_next);
    end
  end

endmodule

FILE: sv/bil_checker.sv
// Port-level checks for the bounded insertable list unit, with its bind.
module bil_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input bil_pkg::bil_out_t out_item
);
  import bil_pkg::*;

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_FULL ||
                   out_item.status == ST_OOB))
    else $error("undefined status code");

  // a full report leaves the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FULL |-> out_item.count_now == 5'(CAPACITY))
    else $error("full status with count below capacity");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_OOB |-> out_item.read_data == '0)
    else $error("data returned with out-of-bounds status");

endmodule

bind bounded_insertable_list_unit bil_checker #(.CAPACITY(CAPACITY)) u_bil_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: bench/tb.sv
// Self-checking bench for the bounded insertable list unit: directed table, then random words.
`timescale 1ns / 100ps

module tb;
  import bil_pkg::*;

  localparam int LIST_CAP     = 16;
  localparam int RANDOM_WORDS = 550;
  localparam int HOLD_AT      = 150;  // random word at which the receiver holds off
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_AT     = 400;  // random word before which the sender waits for all replies
  localparam int STEADY_FROM  = 250;  // window of random words with no idling on either side
  localparam int STEADY_TO    = 350;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PRINT_CAP    = 40;

  // The package names seven operations; the eighth code does nothing
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // One line of the directed table: a word, how many times to send it (the data
  // steps by one per copy), and optionally a reply typed in by hand.
  typedef struct {
    bil_in_t  word;
    int       copies;
    bit       typed;
    bil_out_t want;
  } script_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bil_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bil_out_t out_item;

  // Own copy of the list, advanced on every accepted input word
  logic [31:0] list_words [LIST_CAP];
  int          list_len;

  bil_out_t    replies_due [$];
  bil_out_t    want;
  bil_out_t    drive_want;
  bit          drive_typed = 1'b0;
  bit          steady = 1'b0;
  bit          growing = 1'b1;
  int          offered = -1;
  int          err_count = 0;
  int          cycles = 0;
  script_row_t script [$];

  bounded_insertable_list_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("MISMATCH @%0d: %s", cycles, msg);
    err_count++;
  endtask

  // Open a gap at pos and drop the word in, shifting the upper entries along
  function automatic void place_word(input int pos, input logic [31:0] d);
    int k;
    for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
    list_words[pos] = d;
    list_len++;
  endfunction

  // Apply one operation to the bench's list and return the reply it should give
  function automatic bil_out_t apply_list_op(input bil_in_t w);
    bil_out_t r;
    bit       full;
    int       k;
    r = '{status: ST_OK, read_data: 32'd0, count_now: 5'd0};
    full = (list_len >= LIST_CAP);
    case (w.mode)
      MODE_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else place_word(list_len, w.item_data);
      end
      MODE_PUSH_FRONT: begin
        if (full) r.status = ST_FULL;
        else place_word(0, w.item_data);
      end
      MODE_INSERT_AT: begin
        // bounds come before the full test
        if (int'(w.item_index) > list_len) r.status = ST_OOB;
        else if (full) r.status = ST_FULL;
        else place_word(int'(w.item_index), w.item_data);
      end
      MODE_GET_AT: begin
        if (int'(w.item_index) >= list_len) r.status = ST_OOB;
        else r.read_data = list_words[w.item_index];
      end
      MODE_POP_BACK: begin
        if (list_len > 0) begin
          list_len--;
          list_words[list_len] = 32'd0;
        end
      end
      MODE_POP_FRONT: begin
        if (list_len > 0) begin
          for (k = 0; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
          list_words[list_len] = 32'd0;
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k < LIST_CAP; k++) list_words[k] = 32'd0;
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count_now = list_len[4:0];
    return r;
  endfunction

  // Track both handshakes at the rising edge: predict on input, check on output
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = apply_list_op(in_item);
        if (drive_typed) want = drive_want;
        replies_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          note_mismatch("reply arrived with nothing outstanding");
        end else begin
          want = replies_due.pop_front();
          if (out_item.status !== want.status)
            note_mismatch($sformatf("status %0d, wanted %0d", out_item.status, want.status));
          if (out_item.read_data !== want.read_data)
            note_mismatch($sformatf("read_data %h, wanted %h",
                                    out_item.read_data, want.read_data));
          if (out_item.count_now !== want.count_now)
            note_mismatch($sformatf("count_now %0d, wanted %0d",
                                    out_item.count_now, want.count_now));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet window with none
  initial begin : result_drain
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && offered == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 36);
      end
    end
  end

  function automatic script_row_t step_row(input logic [2:0] mode, input logic [4:0] idx,
                                           input logic [31:0] data, input int copies,
                                           input bit typed, input logic [1:0] st,
                                           input logic [4:0] cnt);
    script_row_t s;
    s.word   = '{mode: mode, item_index: idx, item_data: data};
    s.copies = copies;
    s.typed  = typed;
    s.want   = '{status: st, read_data: 32'd0, count_now: cnt};
    return s;
  endfunction

  // Random word, biased so the list swings between empty and full
  function automatic bil_in_t pick_word();
    bil_in_t w;
    int      r;
    if (list_len == LIST_CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (list_len == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
    if ($urandom_range(0, 39) == 0) growing = !growing;
    r = $urandom_range(0, 99);
    if (r < 2) w.mode = MODE_CLEAR;
    else if (r < 4) w.mode = MODE_UNUSED;
    else if (growing) begin
      if (r < 26) w.mode = MODE_PUSH_BACK;
      else if (r < 41) w.mode = MODE_PUSH_FRONT;
      else if (r < 61) w.mode = MODE_INSERT_AT;
      else if (r < 81) w.mode = MODE_GET_AT;
      else if (r < 90) w.mode = MODE_POP_BACK;
      else w.mode = MODE_POP_FRONT;
    end else begin
      if (r < 12) w.mode = MODE_PUSH_BACK;
      else if (r < 18) w.mode = MODE_PUSH_FRONT;
      else if (r < 26) w.mode = MODE_INSERT_AT;
      else if (r < 46) w.mode = MODE_GET_AT;
      else if (r < 73) w.mode = MODE_POP_BACK;
      else w.mode = MODE_POP_FRONT;
    end
    // mostly in-range positions, with some anywhere in the field
    w.item_index = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 4) != 0) begin
      if (w.mode == MODE_INSERT_AT) w.item_index = 5'($urandom_range(0, list_len));
      if (w.mode == MODE_GET_AT && list_len > 0)
        w.item_index = 5'($urandom_range(0, list_len - 1));
    end
    r = $urandom_range(0, 9);
    if (r == 0) w.item_data = 32'd0;
    else if (r == 1) w.item_data = 32'hFFFF_FFFF;
    else w.item_data = $urandom;
    return w;
  endfunction

  // Present one word from a falling edge; return at the falling edge after it is taken
  task automatic send_word(input bil_in_t w);
    in_item  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    bil_in_t w;
    int      r;
    int      k;
    int      n;

    list_len = 0;
    for (k = 0; k < LIST_CAP; k++) list_words[k] = 32'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // empty list: reads, pops and inserts past the end
    script.push_back(step_row(MODE_GET_AT,     5'd0,  32'h0,         1, 1, ST_OOB, 5'd0));
    script.push_back(step_row(MODE_POP_BACK,   5'd0,  32'h0,         1, 1, ST_OK,  5'd0));
    script.push_back(step_row(MODE_POP_FRONT,  5'd0,  32'h0,         1, 1, ST_OK,  5'd0));
    script.push_back(step_row(MODE_INSERT_AT,  5'd1,  32'h1,         1, 1, ST_OOB, 5'd0));
    script.push_back(step_row(MODE_UNUSED,     5'd31, 32'hFFFF_FFFF, 1, 1, ST_OK,  5'd0));
    // build a short list through every way in
    script.push_back(step_row(MODE_PUSH_BACK,  5'd0,  32'hFFFF_FFFF, 1, 1, ST_OK,  5'd1));
    script.push_back(step_row(MODE_PUSH_FRONT, 5'd31, 32'h0,         1, 1, ST_OK,  5'd2));
    script.push_back(step_row(MODE_INSERT_AT,  5'd1,  32'hA5A5_A5A5, 1, 0, ST_OK,  5'd0));
    script.push_back(step_row(MODE_INSERT_AT,  5'd3,  32'h5A5A_5A5A, 1, 0, ST_OK,  5'd0));
    script.push_back(step_row(MODE_INSERT_AT,  5'd0,  32'h8000_0001, 1, 0, ST_OK,  5'd0));
    script.push_back(step_row(MODE_GET_AT,     5'd1,  32'h0,         1, 0, ST_OK,  5'd0));
    script.push_back(step_row(MODE_GET_AT,     5'd4,  32'h0,         1, 0, ST_OK,  5'd0));
    script.push_back(step_row(MODE_POP_FRONT,  5'd0,  32'h0,         1, 0, ST_OK,  5'd0));
    // fill to the brim
    script.push_back(step_row(MODE_PUSH_BACK,  5'd0,  32'h1234_0000, 12, 0, ST_OK, 5'd0));
    // full list: every way in is refused, bounds still win over full
    script.push_back(step_row(MODE_PUSH_BACK,  5'd0,  32'hDEAD_BEEF, 1, 1, ST_FULL, 5'd16));
    script.push_back(step_row(MODE_PUSH_FRONT, 5'd0,  32'hDEAD_BEEF, 1, 1, ST_FULL, 5'd16));
    script.push_back(step_row(MODE_INSERT_AT,  5'd16, 32'hDEAD_BEEF, 1, 1, ST_FULL, 5'd16));
    script.push_back(step_row(MODE_INSERT_AT,  5'd17, 32'hDEAD_BEEF, 1, 1, ST_OOB,  5'd16));
    script.push_back(step_row(MODE_GET_AT,     5'd15, 32'h0,         1, 0, ST_OK,   5'd0));
    script.push_back(step_row(MODE_GET_AT,     5'd16, 32'h0,         1, 1, ST_OOB,  5'd16));
    script.push_back(step_row(MODE_GET_AT,     5'd31, 32'h0,         1, 1, ST_OOB,  5'd16));
    script.push_back(step_row(MODE_POP_BACK,   5'd0,  32'h0,         1, 1, ST_OK,   5'd15));
    script.push_back(step_row(MODE_POP_FRONT,  5'd0,  32'h0,         1, 1, ST_OK,   5'd14));
    script.push_back(step_row(MODE_CLEAR,      5'd0,  32'h0,         1, 1, ST_OK,   5'd0));
    script.push_back(step_row(MODE_GET_AT,     5'd0,  32'h0,         1, 1, ST_OOB,  5'd0));

    @(negedge clk);
    for (r = 0; r < script.size(); r++) begin
      for (k = 0; k < script[r].copies; k++) begin
        w = script[r].word;
        w.item_data = w.item_data + 32'(k);
        drive_typed = script[r].typed;
        drive_want  = script[r].want;
        send_word(w);
        while ($urandom_range(0, 99) < 36) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
    end

    // random part: every reply comes from the bench's own list
    drive_typed = 1'b0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      offered = n;
      steady  = (n >= STEADY_FROM && n < STEADY_TO);
      if (n == DRAIN_AT) begin
        // hold the sender until every outstanding reply is home
        in_valid <= 1'b0;
        do @(negedge clk); while (replies_due.size() != 0);
      end
      send_word(pick_word());
      // idle at random, except in the steady window and while the receiver
      // holds off, so the sender keeps pressing against a full output stage
      while (!steady && n != HOLD_AT && $urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end

    // drop valid, drain, then give any stray reply a chance to show itself
    in_valid <= 1'b0;
    steady = 1'b0;
    do @(negedge clk); while (replies_due.size() != 0);
    repeat (8) @(negedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
